/* hdl/cpd_pkg.sv */
package cpd_pkg;

    // frame delimiter and the code of a full group
    localparam logic [7:0] DELIM     = 8'h00;
    localparam logic [7:0] FULL_CODE = 8'hFF;

    // configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned MAX_LEN_W  = 7;
    localparam logic [0:0]  REG_MAX_LENGTH   = 1'b0;
    localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RESET = 7'd64;

    // result event codes
    typedef enum logic [1:0] {
        EV_DATA     = 2'd0,
        EV_DELIM    = 2'd1,
        EV_OVERFLOW = 2'd2
    } evt_code_t;

    // decoder sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } cpd_state_t;

    // store access strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

/* hdl/cpd_if.sv */
// encoded byte channel
interface cpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// decoded result channel
interface cpd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_event;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_event, output out_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_event, input out_byte, input out_last,
                    output ready);
endinterface

/* hdl/cpd_store.sv */
module cpd_store
    import cpd_pkg::*;
#(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
)
(
    input  logic              clk,
    input  mem_ctl_t          ctl,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rd_data_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // registered read, data holds between reads
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/cpd_cfg.sv */
module cpd_cfg
    import cpd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [MAX_LEN_W-1:0]  max_length
);

    logic                 hit;
    logic                 wr_en;
    logic [MAX_LEN_W-1:0] max_len_reg;
    logic [MAX_LEN_W-1:0] max_len_next;

    // register decode, byte offset bits ignored
    assign hit    = (paddr[APB_ADDR_W-1:2] == REG_MAX_LENGTH);
    assign wr_en  = psel && penable && pwrite && hit;
    assign pready = 1'b1;

    always_comb
    begin
        max_len_next = max_len_reg;
        if (wr_en)
        begin
            max_len_next = pwdata[MAX_LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LENGTH_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    // read back
    assign prdata     = hit ? APB_DATA_W'(max_len_reg) : '0;
    assign max_length = max_len_reg;

endmodule

/* hdl/cpd_ctrl.sv */
module cpd_ctrl
    import cpd_pkg::*;
#(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned FILL_W = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    cpd_in_if.sink               in_ch,
    cpd_out_if.source            out_ch,
    input  logic [MAX_LEN_W-1:0] max_length,
    output mem_ctl_t             mem_ctl,
    output logic [ADDR_W-1:0]    wr_addr,
    output logic [7:0]           wr_data,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [7:0]           rd_data
);

    cpd_state_t        state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        grp_rem_reg, grp_rem_next;
    logic              grp_full_reg, grp_full_next;
    logic              grp_seen_reg, grp_seen_next;
    logic              discard_reg, discard_next;
    logic [FILL_W-1:0] drain_n_reg, drain_n_next;
    logic [FILL_W-1:0] drain_idx_reg, drain_idx_next;
    logic              out_valid_reg, out_valid_next;
    evt_code_t         out_event_reg, out_event_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic              store_full;
    logic              owe_zero;
    logic              drain_last;
    logic [FILL_W-1:0] drain_idx_inc;
    logic [FILL_W-1:0] fill_inc;

    // handshake
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign accept      = in_ch.valid && in_ch.ready;

    // store limit is the smaller of the register and the depth
    assign store_full = (8'(fill_reg) >= 8'(max_length)) || (8'(fill_reg) >= 8'(DEPTH));
    assign owe_zero   = grp_seen_reg && !grp_full_reg;
    assign fill_inc   = fill_reg + 1'b1;

    assign drain_idx_inc = drain_idx_reg + 1'b1;
    assign drain_last    = (drain_idx_inc == drain_n_reg);

    // decode, store writes and packet readout
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        grp_rem_next   = grp_rem_reg;
        grp_full_next  = grp_full_reg;
        grp_seen_next  = grp_seen_reg;
        discard_next   = discard_reg;
        drain_n_next   = drain_n_reg;
        drain_idx_next = drain_idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_event_next = out_event_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        mem_ctl        = '0;
        wr_addr        = fill_reg[ADDR_W-1:0];
        wr_data        = in_ch.in_byte;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.in_byte == DELIM)
                    begin
                        // delimiter ends the frame in every case
                        fill_next     = '0;
                        grp_rem_next  = '0;
                        grp_full_next = 1'b0;
                        grp_seen_next = 1'b0;
                        discard_next  = 1'b0;
                        if (discard_reg)
                        begin
                            // silent end of a discarded frame
                        end
                        else if (grp_rem_reg != 8'd0)
                        begin
                            out_valid_next = 1'b1;
                            out_event_next = EV_DELIM;
                            out_byte_next  = '0;
                            out_last_next  = 1'b1;
                        end
                        else if (fill_reg != '0)
                        begin
                            // release packet, first read goes out now
                            drain_n_next   = fill_reg;
                            drain_idx_next = '0;
                            mem_ctl.rd_en  = 1'b1;
                            rd_addr        = '0;
                            state_next     = ST_EMIT;
                        end
                    end
                    else if (!discard_reg)
                    begin
                        if (grp_rem_reg == 8'd0)
                        begin
                            // code byte
                            if (owe_zero && store_full)
                            begin
                                discard_next   = 1'b1;
                                out_valid_next = 1'b1;
                                out_event_next = EV_OVERFLOW;
                                out_byte_next  = '0;
                                out_last_next  = 1'b1;
                            end
                            else
                            begin
                                if (owe_zero)
                                begin
                                    mem_ctl.wr_en = 1'b1;
                                    wr_data       = DELIM;
                                    fill_next     = fill_inc;
                                end
                                grp_seen_next = 1'b1;
                                grp_rem_next  = in_ch.in_byte - 8'd1;
                                grp_full_next = (in_ch.in_byte == FULL_CODE);
                            end
                        end
                        else if (store_full)
                        begin
                            discard_next   = 1'b1;
                            out_valid_next = 1'b1;
                            out_event_next = EV_OVERFLOW;
                            out_byte_next  = '0;
                            out_last_next  = 1'b1;
                        end
                        else
                        begin
                            // literal data byte
                            mem_ctl.wr_en = 1'b1;
                            fill_next     = fill_inc;
                            grp_rem_next  = grp_rem_reg - 8'd1;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                // read data holds while the output stalls
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = EV_DATA;
                    out_byte_next  = rd_data;
                    out_last_next  = drain_last;
                    drain_idx_next = drain_idx_inc;
                    if (drain_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = drain_idx_inc[ADDR_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            grp_rem_reg   <= '0;
            grp_full_reg  <= 1'b0;
            grp_seen_reg  <= 1'b0;
            discard_reg   <= 1'b0;
            drain_n_reg   <= '0;
            drain_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            grp_rem_reg   <= grp_rem_next;
            grp_full_reg  <= grp_full_next;
            grp_seen_reg  <= grp_seen_next;
            discard_reg   <= discard_next;
            drain_n_reg   <= drain_n_next;
            drain_idx_reg <= drain_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_event_reg <= out_event_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_event = out_event_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.out_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    // fill never passes the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        8'(fill_reg) <= 8'(DEPTH))
        else $error("fill count beyond store depth");

    // readout only runs over a non-empty packet
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (drain_n_reg != '0 && drain_idx_reg < drain_n_reg))
        else $error("readout index outside packet");

    // the last packet byte returns the sequencer to idle
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && drain_last) |=> (state_reg == ST_IDLE))
        else $error("readout did not finish on last byte");

    // error results carry a zero byte and close their run
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg != EV_DATA) |-> (out_byte_reg == 8'd0 && out_last_reg))
        else $error("malformed error result");
`endif

endmodule

/* hdl/cobs_packet_decoder_core.sv */
// COBS frame decoder. Each input item is one received byte; a zero byte ends a
// frame. Decoded bytes go into a packet store with one write port and one read
// port, and a delimiter reads the store back as data results, one entry per cycle
// through its registered read port while the output does not stall, with the last
// byte flagged. A delimiter that releases a packet holds off the input until the
// readout ends. A delimiter inside a group gives one framing error result; a byte
// past the limit min(max_length, STORE_DEPTH) gives one overflow error result,
// after which bytes are dropped until the next delimiter. The store needs no
// clearing after reset. max_length sits at byte address 0 of the configuration
// port (reset value 64) and should only be written while the block is idle.
// Output back-pressure stalls the readout and the input.
module cobs_packet_decoder_core
    import cpd_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    cpd_in_if.sink                in_ch,
    cpd_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
    localparam int unsigned FILL_W = $clog2(STORE_DEPTH + 1);

    logic [MAX_LEN_W-1:0] max_length;
    mem_ctl_t             mem_ctl;
    logic [ADDR_W-1:0]    wr_addr;
    logic [7:0]           wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic [7:0]           rd_data;

    // configuration register
    cpd_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_length (max_length)
    );

    // decoder and readout sequencer
    cpd_ctrl #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W),
        .FILL_W (FILL_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .max_length (max_length),
        .mem_ctl    (mem_ctl),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    // packet store
    cpd_store #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
